// ===== hdl/lpi_pkg.sv =====
// Package for the laser path infill unit: default parameters, field widths,
// point kind and register index codes. No dependencies.
package lpi_pkg;

    localparam int DEF_MAX_SEGMENTS = 32;
    localparam int DEF_COORD_BITS   = 16;
    localparam int LIMIT_BITS       = 16;
    localparam int POS_BITS         = 16;
    localparam int CHAN_BITS        = 8;
    localparam int LANES            = 5;

    localparam logic [1:0] KIND_ORIG    = 2'd0;
    localparam logic [1:0] KIND_INFILL  = 2'd1;
    localparam logic [1:0] KIND_FLYBACK = 2'd2;

    localparam logic [1:0] REG_LIT_LIMIT   = 2'd0;
    localparam logic [1:0] REG_BLANK_LIMIT = 2'd1;

    localparam logic [2:0] LANE_X = 3'd0;
    localparam logic [2:0] LANE_Y = 3'd1;
    localparam logic [2:0] LANE_R = 3'd2;
    localparam logic [2:0] LANE_G = 3'd3;
    localparam logic [2:0] LANE_B = 3'd4;

endpackage

// ===== hdl/laser_path_infill_unit.sv =====
// Laser path infill unit: infill and flyback point generator with one shared
// multiplier for the segment search and one bit-serial divider for the steps.
// Depends on lpi_pkg.
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+-------------------------------------
// in      | sink      | in_valid/in_ready   | pos_x pos_y red green blue frame_end
// out     | source    | out_valid/out_ready | out_x out_y out_red out_green
//         |           |                     | out_blue point_kind run_last
// cfg     | sink      | cfg_valid/cfg_ready | cfg_index cfg_data
//
// Each run (infill or flyback) first forms the squared gap, then tries segment
// counts n one at a time on the shared multiplier, then divides each lane on the
// serial divider (2 lanes infill, 5 flyback) and then steps and emits the points.
// in_ready is high only between items.
// Reset clears the sequencer, the frame state and both limits; a stalled
// output holds the sequencer in place. cfg_ready is always high.
module laser_path_infill_unit #(
    parameter int MAX_SEGMENTS = lpi_pkg::DEF_MAX_SEGMENTS,
    parameter int COORD_BITS   = lpi_pkg::DEF_COORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [lpi_pkg::POS_BITS-1:0]  pos_x,
    input  logic signed [lpi_pkg::POS_BITS-1:0]  pos_y,
    input  logic [lpi_pkg::CHAN_BITS-1:0] red,
    input  logic [lpi_pkg::CHAN_BITS-1:0] green,
    input  logic [lpi_pkg::CHAN_BITS-1:0] blue,
    input  logic                          frame_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [lpi_pkg::POS_BITS-1:0]  out_x,
    output logic signed [lpi_pkg::POS_BITS-1:0]  out_y,
    output logic [lpi_pkg::CHAN_BITS-1:0] out_red,
    output logic [lpi_pkg::CHAN_BITS-1:0] out_green,
    output logic [lpi_pkg::CHAN_BITS-1:0] out_blue,
    output logic [1:0]                    point_kind,
    output logic                          run_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [lpi_pkg::LIMIT_BITS-1:0] cfg_data
);
    import lpi_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int NB  = $clog2(MAX_SEGMENTS + 1);
    localparam int DW  = W + 1;
    localparam int QW  = W + 2;
    localparam int MW  = (W + 1 > LIMIT_BITS + NB) ? (W + 1) : (LIMIT_BITS + NB);
    localparam int PW  = 2 * MW;
    localparam int CW  = $clog2(DW);

    localparam logic [NB-1:0] N_MAX  = NB'(MAX_SEGMENTS);
    localparam logic [NB-1:0] N_LAST = NB'(MAX_SEGMENTS - 1);
    localparam logic [NB-1:0] N_ONE  = NB'(1);
    localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);
    localparam logic [2:0]    LANE_TOP = 3'(LANES - 1);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_PREFLY = 13'b0000000000010,
        ST_SQX    = 13'b0000000000100,
        ST_SQY    = 13'b0000000001000,
        ST_SUM    = 13'b0000000010000,
        ST_TMUL   = 13'b0000000100000,
        ST_TSQ    = 13'b0000001000000,
        ST_TCMP   = 13'b0000010000000,
        ST_ORIG   = 13'b0000100000000,
        ST_DIVLD  = 13'b0001000000000,
        ST_DIV    = 13'b0010000000000,
        ST_STEP   = 13'b0100000000000,
        ST_PUT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [LIMIT_BITS-1:0] lit_lim_reg, lit_lim_next;
    logic [LIMIT_BITS-1:0] blank_lim_reg, blank_lim_next;

    logic                 prev_valid_reg, prev_valid_next;
    logic signed [W-1:0]  prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [W-1:0]  first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic [CHAN_BITS-1:0] first_r_reg, first_r_next, first_g_reg, first_g_next;
    logic [CHAN_BITS-1:0] first_b_reg, first_b_next;

    logic signed [W-1:0]  cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [CHAN_BITS-1:0] cur_r_reg, cur_r_next, cur_g_reg, cur_g_next;
    logic [CHAN_BITS-1:0] cur_b_reg, cur_b_next;
    logic                 cur_end_reg, cur_end_next;

    logic                 fly_reg, fly_next;
    logic signed [W-1:0]  ax_reg, ax_next, ay_reg, ay_next, bx_reg, bx_next, by_reg, by_next;
    logic [LIMIT_BITS-1:0] lim_reg, lim_next;
    logic [NB-1:0]        n_reg, n_next, k_reg, k_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [PW:0]          d2_reg, d2_next;

    logic [2:0]           lane_reg, lane_next;
    logic [CW-1:0]        dcnt_reg, dcnt_next;
    logic [DW-1:0]        dnum_reg, dnum_next, dquo_reg, dquo_next;
    logic [NB-1:0]        drem_reg, drem_next;
    logic                 dneg_reg, dneg_next;

    logic signed [QW-1:0] q_reg [LANES];
    logic signed [QW-1:0] q_next [LANES];
    logic [NB-1:0]        r_reg [LANES];
    logic [NB-1:0]        r_next [LANES];
    logic signed [QW-1:0] dq_reg [LANES];
    logic signed [QW-1:0] dq_next [LANES];
    logic [NB-1:0]        dr_reg [LANES];
    logic [NB-1:0]        dr_next [LANES];

    logic                 out_valid_reg, out_valid_next;
    logic signed [POS_BITS-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [CHAN_BITS-1:0] or_reg, or_next, og_reg, og_next, ob_reg, ob_next;
    logic [1:0]           kind_reg, kind_next;
    logic                 last_reg, last_next;

    // shared multiplier
    logic [MW-1:0]        mul_a, mul_b;
    logic [PW-1:0]        mul_p;

    logic signed [W:0]    dx, dy;
    logic [MW-1:0]        adx, ady;
    logic signed [QW-1:0] lane_a [LANES];
    logic signed [QW-1:0] lane_d [LANES];
    logic signed [QW-1:0] sel_d;
    logic [NB:0]          trial;
    logic                 qbit;
    logic [DW-1:0]        quo_new;
    logic [NB-1:0]        rem_new;
    logic signed [QW-1:0] tv [LANES];
    logic [NB:0]          rs;
    logic signed [QW-1:0] qs;
    logic                 slot_free;
    logic signed [W-1:0]  in_x, in_y;
    logic                 in_lit;
    logic                 fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign fire      = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    assign in_x   = W'(pos_x);
    assign in_y   = W'(pos_y);
    assign in_lit = (red | green | blue) != '0;

    assign dx  = (W + 1)'(bx_reg) - (W + 1)'(ax_reg);
    assign dy  = (W + 1)'(by_reg) - (W + 1)'(ay_reg);
    assign adx = MW'(dx < 0 ? -dx : dx);
    assign ady = MW'(dy < 0 ? -dy : dy);

    assign lane_a[LANE_X] = QW'(ax_reg);
    assign lane_a[LANE_Y] = QW'(ay_reg);
    assign lane_a[LANE_R] = '0;
    assign lane_a[LANE_G] = '0;
    assign lane_a[LANE_B] = '0;
    assign lane_d[LANE_X] = QW'(dx);
    assign lane_d[LANE_Y] = QW'(dy);
    assign lane_d[LANE_R] = QW'({1'b0, first_r_reg});
    assign lane_d[LANE_G] = QW'({1'b0, first_g_reg});
    assign lane_d[LANE_B] = QW'({1'b0, first_b_reg});
    assign sel_d = lane_d[lane_reg];

    always_comb
    begin
        case (state_reg)
            ST_SQX:  begin mul_a = adx; mul_b = adx; end
            ST_SQY:  begin mul_a = ady; mul_b = ady; end
            ST_TMUL: begin mul_a = MW'(n_reg); mul_b = MW'(lim_reg); end
            ST_TSQ:  begin mul_a = prod_reg[MW-1:0]; mul_b = prod_reg[MW-1:0]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // one restoring divide step
    assign trial   = {drem_reg, dnum_reg[DW-1]};
    assign qbit    = trial >= {1'b0, n_reg};
    assign rem_new = qbit ? NB'(trial - {1'b0, n_reg}) : NB'(trial);
    assign quo_new = {dquo_reg[DW-2:0], qbit};

    // truncate the floor quotient toward zero
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            tv[l] = (q_reg[l] < 0 && r_reg[l] != '0) ? q_reg[l] + QW'(1) : q_reg[l];
    end

    always_comb
    begin
        state_next      = state_reg;
        lit_lim_next    = lit_lim_reg;
        blank_lim_next  = blank_lim_reg;
        prev_valid_next = prev_valid_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        first_r_next    = first_r_reg;
        first_g_next    = first_g_reg;
        first_b_next    = first_b_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        cur_r_next      = cur_r_reg;
        cur_g_next      = cur_g_reg;
        cur_b_next      = cur_b_reg;
        cur_end_next    = cur_end_reg;
        fly_next        = fly_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        lim_next        = lim_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        prod_next       = prod_reg;
        d2_next         = d2_reg;
        lane_next       = lane_reg;
        dcnt_next       = dcnt_reg;
        dnum_next       = dnum_reg;
        dquo_next       = dquo_reg;
        drem_next       = drem_reg;
        dneg_next       = dneg_reg;
        q_next          = q_reg;
        r_next          = r_reg;
        dq_next         = dq_reg;
        dr_next         = dr_reg;
        out_valid_next  = out_valid_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        or_next         = or_reg;
        og_next         = og_reg;
        ob_next         = ob_reg;
        kind_next       = kind_reg;
        last_next       = last_reg;
        rs              = '0;
        qs              = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LIT_LIMIT:   lit_lim_next = cfg_data;
                REG_BLANK_LIMIT: blank_lim_next = cfg_data;
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    cur_x_next   = in_x;
                    cur_y_next   = in_y;
                    cur_r_next   = red;
                    cur_g_next   = green;
                    cur_b_next   = blue;
                    cur_end_next = frame_end;
                    fly_next     = 1'b0;
                    n_next       = N_ONE;
                    ax_next      = prev_x_reg;
                    ay_next      = prev_y_reg;
                    bx_next      = in_x;
                    by_next      = in_y;
                    lim_next     = in_lit ? lit_lim_reg : blank_lim_reg;
                    if (!prev_valid_reg)
                    begin
                        first_x_next = in_x;
                        first_y_next = in_y;
                        first_r_next = red;
                        first_g_next = green;
                        first_b_next = blue;
                    end
                    prev_valid_next = !frame_end;
                    prev_x_next     = in_x;
                    prev_y_next     = in_y;
                    if (prev_valid_reg && (in_lit ? lit_lim_reg : blank_lim_reg) != '0)
                        state_next = ST_SQX;
                    else
                        state_next = ST_PREFLY;
                end
            end
            ST_PREFLY:
            begin
                if (cur_end_reg && blank_lim_reg != '0)
                begin
                    fly_next   = 1'b1;
                    ax_next    = cur_x_reg;
                    ay_next    = cur_y_reg;
                    bx_next    = first_x_reg;
                    by_next    = first_y_reg;
                    lim_next   = blank_lim_reg;
                    n_next     = N_ONE;
                    state_next = ST_SQX;
                end
                else
                begin
                    fly_next   = 1'b0;
                    state_next = ST_ORIG;
                end
            end
            ST_SQX:
            begin
                prod_next  = mul_p;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                d2_next    = {1'b0, prod_reg};
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                d2_next    = d2_reg + {1'b0, prod_reg};
                state_next = ST_TMUL;
            end
            ST_TMUL:
            begin
                prod_next  = mul_p;
                state_next = ST_TSQ;
            end
            ST_TSQ:
            begin
                prod_next  = mul_p;
                state_next = ST_TCMP;
            end
            ST_TCMP:
            begin
                if ({1'b0, prod_reg} >= d2_reg || n_reg == N_LAST)
                begin
                    if ({1'b0, prod_reg} < d2_reg)
                        n_next = N_MAX;
                    if (fly_reg)
                        state_next = ST_ORIG;
                    else if ({1'b0, prod_reg} < d2_reg || n_reg != N_ONE)
                    begin
                        lane_next  = LANE_X;
                        state_next = ST_DIVLD;
                    end
                    else
                        state_next = ST_PREFLY;
                end
                else
                begin
                    n_next     = n_reg + N_ONE;
                    state_next = ST_TMUL;
                end
            end
            ST_ORIG:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    ox_next        = POS_BITS'(cur_x_reg);
                    oy_next        = POS_BITS'(cur_y_reg);
                    or_next        = cur_r_reg;
                    og_next        = cur_g_reg;
                    ob_next        = cur_b_reg;
                    kind_next      = KIND_ORIG;
                    last_next      = !(fly_reg && n_reg != N_ONE);
                    if (fly_reg && n_reg != N_ONE)
                    begin
                        lane_next  = LANE_X;
                        state_next = ST_DIVLD;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_DIVLD:
            begin
                dneg_next         = sel_d < 0;
                dnum_next         = DW'(sel_d < 0 ? -sel_d : sel_d);
                dquo_next         = '0;
                drem_next         = '0;
                dcnt_next         = '0;
                q_next[lane_reg]  = lane_a[lane_reg];
                r_next[lane_reg]  = '0;
                state_next        = ST_DIV;
            end
            ST_DIV:
            begin
                dnum_next = {dnum_reg[DW-2:0], 1'b0};
                dquo_next = quo_new;
                drem_next = rem_new;
                dcnt_next = dcnt_reg + CW'(1);
                if (dcnt_reg == DIV_LAST)
                begin
                    // floor division: negative steps borrow one when a remainder is left
                    if (dneg_reg && rem_new != '0)
                    begin
                        dq_next[lane_reg] = -QW'(quo_new) - QW'(1);
                        dr_next[lane_reg] = n_reg - rem_new;
                    end
                    else
                    begin
                        dq_next[lane_reg] = dneg_reg ? -QW'(quo_new) : QW'(quo_new);
                        dr_next[lane_reg] = rem_new;
                    end
                    if (lane_reg == (fly_reg ? LANE_TOP : LANE_Y))
                    begin
                        k_next     = N_ONE;
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        lane_next  = lane_reg + 3'd1;
                        state_next = ST_DIVLD;
                    end
                end
            end
            ST_STEP:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rs = {1'b0, r_reg[l]} + {1'b0, dr_reg[l]};
                    qs = q_reg[l] + dq_reg[l];
                    if (rs >= {1'b0, n_reg})
                    begin
                        r_next[l] = NB'(rs - {1'b0, n_reg});
                        q_next[l] = qs + QW'(1);
                    end
                    else
                    begin
                        r_next[l] = NB'(rs);
                        q_next[l] = qs;
                    end
                end
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    ox_next        = POS_BITS'(tv[LANE_X]);
                    oy_next        = POS_BITS'(tv[LANE_Y]);
                    if (fly_reg)
                    begin
                        or_next   = CHAN_BITS'(tv[LANE_R]);
                        og_next   = CHAN_BITS'(tv[LANE_G]);
                        ob_next   = CHAN_BITS'(tv[LANE_B]);
                        kind_next = KIND_FLYBACK;
                    end
                    else
                    begin
                        or_next   = cur_r_reg;
                        og_next   = cur_g_reg;
                        ob_next   = cur_b_reg;
                        kind_next = KIND_INFILL;
                    end
                    last_next = fly_reg && (k_reg == n_reg - N_ONE);
                    k_next    = k_reg + N_ONE;
                    if (k_reg == n_reg - N_ONE)
                        state_next = fly_reg ? ST_IDLE : ST_PREFLY;
                    else
                        state_next = ST_STEP;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lit_lim_reg    <= '0;
            blank_lim_reg  <= '0;
            prev_valid_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            first_r_reg    <= '0;
            first_g_reg    <= '0;
            first_b_reg    <= '0;
            out_valid_reg  <= 1'b0;
            fly_reg        <= 1'b0;
            n_reg          <= N_ONE;
            k_reg          <= N_ONE;
            lane_reg       <= LANE_X;
            dcnt_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            lit_lim_reg    <= lit_lim_next;
            blank_lim_reg  <= blank_lim_next;
            prev_valid_reg <= prev_valid_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            first_x_reg    <= first_x_next;
            first_y_reg    <= first_y_next;
            first_r_reg    <= first_r_next;
            first_g_reg    <= first_g_next;
            first_b_reg    <= first_b_next;
            out_valid_reg  <= out_valid_next;
            fly_reg        <= fly_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            lane_reg       <= lane_next;
            dcnt_reg       <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        cur_r_reg   <= cur_r_next;
        cur_g_reg   <= cur_g_next;
        cur_b_reg   <= cur_b_next;
        cur_end_reg <= cur_end_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        lim_reg     <= lim_next;
        prod_reg    <= prod_next;
        d2_reg      <= d2_next;
        dnum_reg    <= dnum_next;
        dquo_reg    <= dquo_next;
        drem_reg    <= drem_next;
        dneg_reg    <= dneg_next;
        q_reg       <= q_next;
        r_reg       <= r_next;
        dq_reg      <= dq_next;
        dr_reg      <= dr_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        or_reg      <= or_next;
        og_reg      <= og_next;
        ob_reg      <= ob_next;
        kind_reg    <= kind_next;
        last_reg    <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = ox_reg;
    assign out_y      = oy_reg;
    assign out_red    = or_reg;
    assign out_green  = og_reg;
    assign out_blue   = ob_reg;
    assign point_kind = kind_reg;
    assign run_last   = last_reg;

    a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_STEP) |-> (n_reg >= 2 && n_reg <= N_MAX))
        else $error("segment count out of range during stepping");

    a_k_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUT |-> (k_reg >= N_ONE && k_reg < n_reg))
        else $error("step index not below segment count");

    a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUT |-> (r_reg[LANE_X] < n_reg && r_reg[LANE_Y] < n_reg))
        else $error("lerp remainder not below segment count");

    a_flyback_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_INFILL) |-> !last_reg)
        else $error("infill point flagged as last of its run");

endmodule

// ===== tb/lpi_checker.sv =====
// Point stream checker for the laser path infill unit: watches the point, result
// and register channels, predicts the emitted points and compares them.
// Depends on lpi_pkg.
module lpi_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        frame_end,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] out_x,
    input  logic [15:0] out_y,
    input  logic [7:0]  out_red,
    input  logic [7:0]  out_green,
    input  logic [7:0]  out_blue,
    input  logic [1:0]  point_kind,
    input  logic        run_last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import lpi_pkg::*;

    localparam int SEGS = DEF_MAX_SEGMENTS;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [1:0]  kind;
        logic        last;
    } point_t;

    point_t      point_q[$];
    logic [15:0] lit_limit, blank_limit;
    bit          have_prev;
    longint      prev_x, prev_y, first_x, first_y;
    logic [7:0]  first_r, first_g, first_b;

    assign pending = point_q.size();

    function automatic longint segments(longint ax, longint ay, longint bx, longint by,
                                        longint lim);
        longint d2;
        d2 = (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
        if (lim == 0)
            return 1;
        for (longint n = 1; n < SEGS; n++)
            if ((n * lim) * (n * lim) >= d2)
                return n;
        return SEGS;
    endfunction

    function automatic longint step_pos(longint a, longint b, longint k, longint n);
        return (a * n + k * (b - a)) / n;
    endfunction

    function automatic void push_point(longint x, longint y, longint r, longint g,
                                       longint b, logic [1:0] kind);
        point_t p;
        p.x = x[15:0];
        p.y = y[15:0];
        p.r = r[7:0];
        p.g = g[7:0];
        p.b = b[7:0];
        p.kind = kind;
        p.last = 1'b0;
        point_q.push_back(p);
    endfunction

    task automatic predict_points();
        longint x, y, n, lim;
        bit     lit;
        x = longint'($signed(pos_x));
        y = longint'($signed(pos_y));
        lit = (red | green | blue) != 0;
        if (have_prev) begin
            lim = lit ? lit_limit : blank_limit;
            n = segments(prev_x, prev_y, x, y, lim);
            for (longint k = 1; k < n; k++)
                push_point(step_pos(prev_x, x, k, n), step_pos(prev_y, y, k, n),
                           red, green, blue, KIND_INFILL);
        end else begin
            first_x = x;
            first_y = y;
            first_r = red;
            first_g = green;
            first_b = blue;
        end
        push_point(x, y, red, green, blue, KIND_ORIG);
        if (frame_end) begin
            if (blank_limit != 0) begin
                n = segments(x, y, first_x, first_y, blank_limit);
                for (longint k = 1; k < n; k++)
                    push_point(step_pos(x, first_x, k, n), step_pos(y, first_y, k, n),
                               first_r * k / n, first_g * k / n, first_b * k / n,
                               KIND_FLYBACK);
            end
            have_prev = 0;
        end else begin
            have_prev = 1;
        end
        prev_x = x;
        prev_y = y;
        point_q[$].last = 1'b1;
    endtask

    task automatic compare_point();
        point_t e;
        if (point_q.size() == 0) begin
            $error("unexpected point x=%0h y=%0h", out_x, out_y);
            fail_count++;
            return;
        end
        e = point_q.pop_front();
        if (out_x !== e.x) begin $error("out_x exp %0h got %0h", e.x, out_x); fail_count++; end
        if (out_y !== e.y) begin $error("out_y exp %0h got %0h", e.y, out_y); fail_count++; end
        if (out_red !== e.r) begin
            $error("out_red exp %0h got %0h", e.r, out_red); fail_count++;
        end
        if (out_green !== e.g) begin
            $error("out_green exp %0h got %0h", e.g, out_green); fail_count++;
        end
        if (out_blue !== e.b) begin
            $error("out_blue exp %0h got %0h", e.b, out_blue); fail_count++;
        end
        if (point_kind !== e.kind) begin
            $error("point_kind exp %0d got %0d", e.kind, point_kind); fail_count++;
        end
        if (run_last !== e.last) begin
            $error("run_last exp %0d got %0d", e.last, run_last); fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fail_count  = 0;
            lit_limit   = '0;
            blank_limit = '0;
            have_prev   = 0;
            prev_x = 0; prev_y = 0; first_x = 0; first_y = 0;
            first_r = 0; first_g = 0; first_b = 0;
            point_q.delete();
        end else begin
            if (out_valid && out_ready)
                compare_point();
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_LIT_LIMIT)
                    lit_limit = cfg_data;
                else if (cfg_index == REG_BLANK_LIMIT)
                    blank_limit = cfg_data;
            end
            if (in_valid && in_ready)
                predict_points();
        end
    end
endmodule

// ===== tb/tb.sv =====
// Top of the laser path infill unit testbench: clock, reset, point and register
// stimulus, and the verdict. Depends on lpi_pkg, laser_path_infill_unit, lpi_checker.
module tb;
    import lpi_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0, in_ready;
    logic [15:0] pos_x = 0, pos_y = 0;
    logic [7:0]  red = 0, green = 0, blue = 0;
    logic        frame_end = 0;
    logic        out_valid, out_ready = 0;
    logic [15:0] out_x, out_y;
    logic [7:0]  out_red, out_green, out_blue;
    logic [1:0]  point_kind;
    logic        run_last;
    logic        cfg_valid = 0, cfg_ready;
    logic [1:0]  cfg_index = REG_LIT_LIMIT;
    logic [15:0] cfg_data = 0;
    int          fail_count, pending;
    longint      cycles = 0;

    localparam longint CYCLE_LIMIT = 4000000;

    always #1 clk = ~clk;

    laser_path_infill_unit u_dut (.*);
    lpi_checker u_chk (.*);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** laser_path_infill_unit: FAILED **");
            $finish;
        end
    end

    // Result side: random stall before each beat, with calm stretches.
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap != 0) begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Hold cfg_valid after the beat; the next write or drain() moves it.
    task automatic write_limit(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Hold in_valid after the beat; drop it only for an idle gap or in drain().
    task automatic send_point(logic [15:0] x, logic [15:0] y, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b, logic fe, bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1;
        pos_x     <= x;
        pos_y     <= y;
        red       <= r;
        green     <= g;
        blue      <= b;
        frame_end <= fe;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drain all points, then leave room for the idle sequencer to settle.
    task automatic drain();
        in_valid  <= 0;
        cfg_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic random_frame(int len, int spread);
        logic [7:0] r, g, b;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                r = 0; g = 0; b = 0;
            end else begin
                r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            end
            if (spread == 0)
                send_point(16'($urandom), 16'($urandom), r, g, b, i == len - 1, 1);
            else
                send_point(16'($urandom_range(0, 2 * spread) - spread),
                           16'($urandom_range(0, 2 * spread) - spread),
                           r, g, b, i == len - 1, $urandom_range(0, 3) != 0);
        end
    endtask

    initial begin
        logic [15:0] lits[5], blanks[5];
        lits   = '{16'd0, 16'd1, 16'd300, 16'hFFFF, 16'd2000};
        blanks = '{16'd0, 16'd1, 16'd500, 16'hFFFF, 16'd40};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Limits off: pass-through, then extremes with infill and flyback.
        send_point(16'h7FFF, 16'h8000, 8'hFF, 8'hFF, 8'hFF, 0, 1);
        send_point(16'h8000, 16'h7FFF, 8'h00, 8'h00, 8'h00, 1, 1);
        drain();
        write_limit(REG_LIT_LIMIT, 16'd1000);
        write_limit(REG_BLANK_LIMIT, 16'd1);
        write_limit(2'd2, 16'd7);
        write_limit(2'd3, 16'hFFFF);
        drain();
        send_point(16'h8000, 16'h8000, 8'hFF, 8'h80, 8'h01, 0, 1);
        send_point(16'h7FFF, 16'h7FFF, 8'h01, 8'h00, 8'h00, 0, 1);
        send_point(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 1);
        send_point(16'h0100, 16'h0100, 8'h00, 8'hFF, 8'h00, 0, 1);
        send_point(16'h0101, 16'h0100, 8'h00, 8'h00, 8'hFF, 1, 1);
        // Single-point frame: zero flyback gap.
        send_point(16'h1234, 16'hEDCB, 8'h55, 8'hAA, 8'h0F, 1, 1);
        drain();
        write_limit(REG_LIT_LIMIT, 16'hFFFF);
        write_limit(REG_BLANK_LIMIT, 16'hFFFF);
        drain();
        send_point(16'h8000, 16'h8000, 8'h10, 8'h20, 8'h30, 0, 1);
        send_point(16'h7FFF, 16'h7FFF, 8'h10, 8'h20, 8'h30, 0, 1);
        send_point(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 1, 1);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_limit(REG_LIT_LIMIT, (ph < 5) ? lits[ph] : 16'($urandom));
            write_limit(REG_BLANK_LIMIT, (ph < 5) ? blanks[(ph + 2) % 5] : 16'($urandom));
            drain();
            for (int f = 0; f < 8; f++) begin
                int len;
                len = $urandom_range(1, 7);
                random_frame(len, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 20000));
            end
            drain();
        end

        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("** laser_path_infill_unit: PASSED **");
        else
            $display("** laser_path_infill_unit: FAILED **");
        $finish;
    end
endmodule
